>>> src/height_map_text_parser_top_macros.svh
// assertion macros shared by the parser top level
`ifndef HEIGHT_MAP_TEXT_PARSER_TOP_MACROS_SVH
`define HEIGHT_MAP_TEXT_PARSER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HMTP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define HMTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/hmtp_pkg.sv
`timescale 1ns / 1ps
package hmtp_pkg;

    // default sizing
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;
    localparam int CMD_DEPTH       = 4;
    localparam int RES_DEPTH       = 4;

    // result kinds
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_ROW   = 1'b1;

    // input request
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } hmtp_in_t;

    // result request
    typedef struct packed {
        logic               kind;
        logic signed [31:0] height;
        logic [31:0]        color;
        logic [9:0]         column;
        logic [9:0]         row;
        logic [10:0]        token_count;
        logic               short_row;
    } hmtp_out_t;

    // byte classes seen by the parser core
    typedef enum logic [2:0] {
        C_EOI   = 3'd0,
        C_NL    = 3'd1,
        C_SEP   = 3'd2,
        C_SIGN  = 3'd3,
        C_COMMA = 3'd4,
        C_LOWX  = 3'd5,
        C_OTHER = 3'd6
    } hmtp_cls_t;

    // classified byte handed from front to back
    typedef struct packed {
        hmtp_cls_t  cls;
        logic       minus;
        logic       digit;
        logic       hexd;
        logic       zero;
        logic [3:0] nib;
    } hmtp_cmd_t;

endpackage

>>> src/hmtp_fifo.sv
`timescale 1ns / 1ps
module hmtp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
endmodule

>>> src/hmtp_front.sv
`timescale 1ns / 1ps
module hmtp_front (
    input  hmtp_pkg::hmtp_in_t  item,
    input  logic                push,
    output logic                full,
    output hmtp_pkg::hmtp_cmd_t cmd,
    output logic                cmd_wr,
    input  logic                cmd_full
);
    import hmtp_pkg::*;

    logic [7:0] b;

    assign b = item.byte_in;

    // byte class, digit and nibble decode
    always_comb
    begin
        if (item.end_of_input)
        begin
            cmd.cls = C_EOI;
        end
        else if (b == 8'h0A)
        begin
            cmd.cls = C_NL;
        end
        else if (b inside {8'h20, [8'h09:8'h0D]})
        begin
            cmd.cls = C_SEP;
        end
        else if (b inside {8'h2B, 8'h2D})
        begin
            cmd.cls = C_SIGN;
        end
        else if (b == 8'h2C)
        begin
            cmd.cls = C_COMMA;
        end
        else if (b == 8'h78)
        begin
            cmd.cls = C_LOWX;
        end
        else
        begin
            cmd.cls = C_OTHER;
        end

        cmd.minus = (b == 8'h2D);
        cmd.zero  = (b == 8'h30);
        cmd.digit = (b inside {[8'h30:8'h39]});
        cmd.hexd  = 1'b1;
        if (b inside {[8'h30:8'h39]})
        begin
            cmd.nib = b[3:0];
        end
        else if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            cmd.nib = b[3:0] + 4'd9;
        end
        else
        begin
            cmd.nib  = 4'd0;
            cmd.hexd = 1'b0;
        end
    end

    // request handshake into the command queue
    assign cmd_wr = push && !cmd_full;
    assign full   = cmd_full;
endmodule

>>> src/hmtp_back.sv
`timescale 1ns / 1ps
module hmtp_back #(
    parameter int MAX_COLUMNS = hmtp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = hmtp_pkg::MAX_ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hmtp_pkg::hmtp_cmd_t cmd,
    input  logic                cmd_empty,
    output logic                cmd_rd,
    output hmtp_pkg::hmtp_out_t res,
    output logic                res_wr,
    input  logic                res_full
);
    import hmtp_pkg::*;

    localparam int COL_LIM = (MAX_COLUMNS < 2047) ? MAX_COLUMNS : 2047;
    localparam int COL_CAP = (MAX_COLUMNS - 1 < 1023) ? MAX_COLUMNS - 1 : 1023;
    localparam int ROW_CAP = (MAX_ROWS - 1 < 1023) ? MAX_ROWS - 1 : 1023;
    localparam logic [10:0] COL_LIM_V = 11'(COL_LIM);
    localparam logic [10:0] COL_CAP_V = 11'(COL_CAP);
    localparam logic [9:0]  ROW_CAP_V = 10'(ROW_CAP);
    localparam logic [3:0]  TAIL_RGBA = 4'd8;
    localparam logic [3:0]  TAIL_SAT  = 4'd9;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_NUMBER = 6'b000010,
        PH_PREFIX = 6'b000100,
        PH_HEX    = 6'b001000,
        PH_TAIL   = 6'b010000,
        PH_JUNK   = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [31:0] height_reg, height_next;
    logic [31:0] color_reg, color_next;
    logic        zero_seen_reg, zero_seen_next;
    logic [3:0]  tail_reg, tail_next;
    logic [10:0] col_reg, col_next;
    logic [9:0]  row_reg, row_next;
    logic [10:0] first_reg, first_next;
    logic        known_reg, known_next;
    logic        text_reg, text_next;
    hmtp_out_t   pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;

    logic        has_tok;
    logic [10:0] col_after;
    logic [10:0] col_sat;
    hmtp_out_t   tok_res;
    hmtp_out_t   sum_res;
    logic        emit_tok;
    logic        emit_sum;
    logic        num_step;

    // pending token and row summary results
    always_comb
    begin
        has_tok   = (phase_reg != PH_IDLE);
        col_after = (has_tok && col_reg < COL_LIM_V) ? col_reg + 1'b1 : col_reg;
        col_sat   = (col_reg > COL_CAP_V) ? COL_CAP_V : col_reg;

        tok_res.kind        = KIND_POINT;
        tok_res.height      = neg_reg ? 32'(0 - height_reg) : height_reg;
        if (phase_reg == PH_HEX || phase_reg == PH_TAIL)
        begin
            tok_res.color = (tail_reg == TAIL_RGBA) ? color_reg
                                                    : {color_reg[23:0], 8'hFF};
        end
        else
        begin
            tok_res.color = 32'hFFFF_FFFF;
        end
        tok_res.column      = col_sat[9:0];
        tok_res.row         = row_reg;
        tok_res.token_count = '0;
        tok_res.short_row   = 1'b0;

        sum_res.kind        = KIND_ROW;
        sum_res.height      = '0;
        sum_res.color       = '0;
        sum_res.column      = '0;
        sum_res.row         = row_reg;
        sum_res.token_count = col_after;
        sum_res.short_row   = known_reg && (col_after < first_reg);
    end

    // command execution
    always_comb
    begin
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        height_next     = height_reg;
        color_next      = color_reg;
        zero_seen_next  = zero_seen_reg;
        tail_next       = tail_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        first_next      = first_reg;
        known_next      = known_reg;
        text_next       = text_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cmd_rd          = 1'b0;
        res_wr          = 1'b0;
        res             = pend_reg;
        emit_tok        = 1'b0;
        emit_sum        = 1'b0;
        num_step        = 1'b0;

        if (pend_valid_reg)
        begin
            // second result of the previous command
            if (!res_full)
            begin
                res_wr          = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (!cmd_empty && !res_full)
        begin
            cmd_rd = 1'b1;
            case (cmd.cls)
                C_EOI:
                begin
                    emit_tok = has_tok;
                    emit_sum = text_reg;
                end
                C_NL:
                begin
                    emit_tok = has_tok;
                    emit_sum = 1'b1;
                end
                C_SEP:
                begin
                    emit_tok  = has_tok;
                    text_next = 1'b1;
                end
                default:
                begin
                    text_next = 1'b1;
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (cmd.cls == C_SIGN)
                            begin
                                neg_next   = cmd.minus;
                                phase_next = PH_NUMBER;
                            end
                            else
                            begin
                                num_step = 1'b1;
                            end
                        end
                        PH_NUMBER:
                        begin
                            num_step = 1'b1;
                        end
                        PH_PREFIX:
                        begin
                            if (!zero_seen_reg && cmd.zero)
                            begin
                                zero_seen_next = 1'b1;
                            end
                            else if (zero_seen_reg && cmd.cls == C_LOWX)
                            begin
                                phase_next = PH_HEX;
                            end
                            else
                            begin
                                phase_next = PH_JUNK;
                            end
                        end
                        PH_HEX:
                        begin
                            if (tail_reg < TAIL_SAT)
                            begin
                                tail_next = tail_reg + 1'b1;
                            end
                            if (cmd.hexd)
                            begin
                                color_next = {color_reg[27:0], cmd.nib};
                            end
                            else
                            begin
                                phase_next = PH_TAIL;
                            end
                        end
                        PH_TAIL:
                        begin
                            if (tail_reg < TAIL_SAT)
                            begin
                                tail_next = tail_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                    // a digit extends the number; a comma or anything else ends it
                    if (num_step)
                    begin
                        if (cmd.digit)
                        begin
                            height_next = {height_reg[28:0], 3'b000}
                                        + {height_reg[30:0], 1'b0}
                                        + {28'd0, cmd.nib};
                            phase_next  = PH_NUMBER;
                        end
                        else if (cmd.cls == C_COMMA)
                        begin
                            zero_seen_next = 1'b0;
                            phase_next     = PH_PREFIX;
                        end
                        else
                        begin
                            phase_next = PH_JUNK;
                        end
                    end
                end
            endcase

            // token finished: clear token state, count the column
            if (emit_tok)
            begin
                phase_next     = PH_IDLE;
                neg_next       = 1'b0;
                height_next    = '0;
                color_next     = '0;
                zero_seen_next = 1'b0;
                tail_next      = '0;
                col_next       = col_after;
            end

            // row ended
            if (cmd.cls == C_NL)
            begin
                if (!known_reg)
                begin
                    first_next = col_after;
                    known_next = 1'b1;
                end
                col_next  = '0;
                text_next = 1'b0;
                if (row_reg < ROW_CAP_V)
                begin
                    row_next = row_reg + 1'b1;
                end
            end

            // end of input returns everything to reset
            if (cmd.cls == C_EOI)
            begin
                phase_next     = PH_IDLE;
                neg_next       = 1'b0;
                height_next    = '0;
                color_next     = '0;
                zero_seen_next = 1'b0;
                tail_next      = '0;
                col_next       = '0;
                row_next       = '0;
                first_next     = '0;
                known_next     = 1'b0;
                text_next      = 1'b0;
            end

            // result writes, second one held until the result queue has room
            if (emit_tok)
            begin
                res    = tok_res;
                res_wr = 1'b1;
                if (emit_sum)
                begin
                    pend_next       = sum_res;
                    pend_valid_next = 1'b1;
                end
            end
            else if (emit_sum)
            begin
                res    = sum_res;
                res_wr = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            neg_reg        <= 1'b0;
            height_reg     <= '0;
            color_reg      <= '0;
            zero_seen_reg  <= 1'b0;
            tail_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            first_reg      <= '0;
            known_reg      <= 1'b0;
            text_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            height_reg     <= height_next;
            color_reg      <= color_next;
            zero_seen_reg  <= zero_seen_next;
            tail_reg       <= tail_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            first_reg      <= first_next;
            known_reg      <= known_next;
            text_reg       <= text_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // held second result
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end
endmodule

>>> src/height_map_text_parser_top.sv
`timescale 1ns / 1ps
// Height-map text parser.
// Input channel: one text byte per request on item, taken when push is high
// and full is low. With item.end_of_input set the byte is ignored, the
// pending token and row are flushed and the parser returns to its start state.
// Result channel: point and row-summary results in text order on result,
// valid while empty is low, taken when pop is high.
// Throughput: one byte per cycle while the result queue has room. A byte that
// closes both a token and a row yields two results and holds the parser core
// while the second result is written. A four-entry command queue sits between
// the byte classifier and the parser core, and a four-entry result queue sits
// at the output; both are registered, and a result reaches the result ports
// through both of them, the second of a pair after the first.
// When the receiver stalls, the result queue fills, the core stops, the
// command queue fills and full rises; nothing is dropped.
// Reset empties both queues and clears all row and token state.
`include "height_map_text_parser_top_macros.svh"
module height_map_text_parser_top #(
    parameter int MAX_COLUMNS = hmtp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = hmtp_pkg::MAX_ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hmtp_pkg::hmtp_in_t  item,
    input  logic                push,
    output logic                full,
    output hmtp_pkg::hmtp_out_t result,
    output logic                empty,
    input  logic                pop
);
    import hmtp_pkg::*;

    hmtp_cmd_t cmd_in;
    hmtp_cmd_t cmd_out;
    logic      cmd_wr;
    logic      cmd_full;
    logic      cmd_empty;
    logic      cmd_rd;
    hmtp_out_t res_in;
    logic      res_wr;
    logic      res_full;
    logic      res_rd;

    // byte classifier
    hmtp_front u_front (
        .item     (item),
        .push     (push),
        .full     (full),
        .cmd      (cmd_in),
        .cmd_wr   (cmd_wr),
        .cmd_full (cmd_full)
    );

    // command queue
    hmtp_fifo #(
        .WIDTH ($bits(hmtp_cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_rd),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // parser core
    hmtp_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_rd    (cmd_rd),
        .res       (res_in),
        .res_wr    (res_wr),
        .res_full  (res_full)
    );

    // result queue
    assign res_rd = pop && !empty;

    hmtp_fifo #(
        .WIDTH ($bits(hmtp_out_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (res_rd),
        .rd_data (result),
        .empty   (empty)
    );

    // queue discipline of the core and classifier
    `HMTP_ASSERT_IMPL(a_res_room, res_wr, !res_full)
    `HMTP_ASSERT_IMPL(a_cmd_avail, cmd_rd, !cmd_empty)
    `HMTP_ASSERT_NEXT(a_cmd_lands, push && !full, !cmd_empty)
endmodule
